// ===== rtl/crlz_pkg.sv =====
// ============================================================================
// crlz_pkg: shared types and constants for the compressed RTF decompressor
// Holds the item structs, the controller/datapath command and status
// bundles, the controller states and the RTF dictionary table.
// ============================================================================
package crlz_pkg;

  localparam int WINDOW_SIZE    = 4096;
  localparam int DICT_LENGTH    = 207;
  localparam int POS_W          = $clog2(WINDOW_SIZE);
  localparam int FILL_W         = POS_W + 1;
  localparam int FLAGS_PER_BYTE = 8;
  localparam int FIDX_W         = $clog2(FLAGS_PER_BYTE) + 1;
  localparam int RUN_BIAS       = 2;
  localparam int LEN_W          = 5;
  localparam int CNT_W          = 32;
  localparam int HEADER_BYTES   = 16;
  localparam int SIZE_ADJUST    = 4;
  localparam int REF_BYTES      = 2;
  localparam int CFG_IDX_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPRESSED_SIZE = 1'b0,
    CFG_RAW_SIZE        = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_stream;
  } crlz_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } crlz_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;           // reload stream state before this byte
    logic flags_take;     // byte is a flag byte
    logic ref_high_take;  // byte is the high half of a reference
    logic literal;        // byte is a literal: store and emit
    logic ref_start;      // byte is the low half of a reference: set up run
    logic fetch;          // issue first window read of a run
    logic copy;           // move one run byte to the output and the window
  } crlz_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic new_stream;
    logic budget_ok;
    logic flag_next;
    logic flag_bit;
    logic run_last;
    logic out_busy;
  } crlz_sts_t;

  typedef enum logic [1:0] {
    ST_TOKEN,
    ST_LOW,
    ST_FETCH,
    ST_COPY
  } ctrl_state_e;

  // Preset dictionary, first character in the top byte
  localparam logic [DICT_LENGTH*8-1:0] RTF_DICT = {
    "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
    "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscrip",
    "t \\fdecor MS Sans SerifSymbolArialTimes Ne",
    "w RomanCourier{\\colortbl\\red0\\green0\\blue0",
    "\015\012\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab",
    "\\tx"
  };

  // Initial window contents: dictionary, then zeros
  function automatic logic [7:0] rtf_dict_byte(input logic [POS_W-1:0] addr);
    int idx;
    idx = int'(addr);
    if (idx < DICT_LENGTH) begin
      return RTF_DICT[8*(DICT_LENGTH-1-idx) +: 8];
    end
    return 8'h00;
  endfunction

endpackage

// ===== rtl/crlz_ram.sv =====
// ============================================================================
// crlz_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data that holds
// while no read is issued.
// ============================================================================
module crlz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/crlz_ctrl.sv =====
// ============================================================================
// crlz_ctrl: token sequencer
// Decides per input byte whether it is a flag byte, literal or reference
// half, and steps the run copy one byte per cycle while the output is free.
// ============================================================================
module crlz_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 out_stall_i,
  input  crlz_pkg::crlz_sts_t  sts_i,
  output crlz_pkg::crlz_cmd_t  cmd_o
);
  import crlz_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_free;
  logic        accept;

  assign out_free = !sts_i.out_busy || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TOKEN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    unique case (state_q)
      ST_TOKEN, ST_LOW: begin
        in_stall_o = !out_free;
        accept     = in_valid_i && out_free;
        if (accept) begin
          cmd_o.load = sts_i.new_stream;
          if (state_q == ST_LOW && !sts_i.new_stream) begin
            cmd_o.ref_start = 1'b1;
            state_d         = ST_FETCH;
          end else begin
            state_d = ST_TOKEN;
            if (sts_i.budget_ok) begin
              if (sts_i.flag_next) begin
                cmd_o.flags_take = 1'b1;
              end else if (sts_i.flag_bit) begin
                cmd_o.ref_high_take = 1'b1;
                state_d             = ST_LOW;
              end else begin
                cmd_o.literal = 1'b1;
              end
            end
          end
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_COPY;
      end
      ST_COPY: begin
        if (out_free) begin
          cmd_o.copy = 1'b1;
          if (sts_i.run_last) begin
            state_d = ST_TOKEN;
          end
        end
      end
      default: state_d = ST_TOKEN;
    endcase
  end

  // at most one datapath action per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.flags_take, cmd_o.ref_high_take, cmd_o.literal,
              cmd_o.ref_start, cmd_o.fetch, cmd_o.copy}))
    else $error("crlz_ctrl: conflicting datapath commands");

  // a held result must never be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_i.out_busy && out_stall_i) |-> !(cmd_o.literal || cmd_o.copy))
    else $error("crlz_ctrl: output register overwritten while stalled");

  // a reference start always leads through the fetch into the copy loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ref_start |=> ##1 (state_q == ST_COPY))
    else $error("crlz_ctrl: reference did not enter the copy loop");

endmodule

// ===== rtl/crlz_datapath.sv =====
// ============================================================================
// crlz_datapath: window, counters and output register
// Holds the size registers, token state, byte counters, the history window
// RAM with its fill count, and the output item register.
// ============================================================================
module crlz_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  crlz_pkg::crlz_cmd_t             cmd_i,
  output crlz_pkg::crlz_sts_t             sts_o,
  input  crlz_pkg::crlz_in_t              in_data_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output crlz_pkg::crlz_out_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [crlz_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [crlz_pkg::CNT_W-1:0]      cfg_data_i
);
  import crlz_pkg::*;

  logic [CNT_W-1:0]  cs_q, cs_d, raw_q, raw_d;
  logic [CNT_W-1:0]  cons_q, cons_d, prod_q, prod_d;
  logic [POS_W-1:0]  wpos_q, wpos_d, rp_q, rp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        flags_q, flags_d, ref_hi_q, ref_hi_d;
  logic [FIDX_W-1:0] fidx_q, fidx_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  crlz_out_t         out_q, out_d;
  logic              use_ram_q, use_ram_d;
  logic [7:0]        alt_q, alt_d;

  logic [CNT_W-1:0]  eff_cons, eff_prod, cons_limit;
  logic [FIDX_W-1:0] eff_fidx;
  logic [7:0]        in_byte, copy_byte, ram_rd, wr_data;
  logic [POS_W-1:0]  rd_addr, win_ofs;
  logic              rd_en, wr_en, fwd, hit_valid, run_last, fill_full;

  assign in_byte    = in_data_i.data_byte;
  assign eff_cons   = in_data_i.new_stream ? CNT_W'(HEADER_BYTES) : cons_q;
  assign eff_prod   = in_data_i.new_stream ? '0 : prod_q;
  assign eff_fidx   = in_data_i.new_stream ? FIDX_W'(FLAGS_PER_BYTE) : fidx_q;
  assign cons_limit = cs_q + CNT_W'(SIZE_ADJUST);
  assign run_last   = (cnt_q == LEN_W'(1));
  assign fill_full  = (fill_q == FILL_W'(WINDOW_SIZE));

  always_comb begin
    sts_o.new_stream = in_data_i.new_stream;
    sts_o.budget_ok  = (eff_cons < cons_limit) && (eff_prod < raw_q);
    sts_o.flag_next  = eff_fidx[FIDX_W-1];
    sts_o.flag_bit   = flags_q[fidx_q[FIDX_W-2:0]];
    sts_o.run_last   = run_last;
    sts_o.out_busy   = out_valid_q;
  end

  // Window read: entries outside the written span read as the preset
  // contents; a read of the slot being written this cycle is forwarded.
  assign copy_byte = use_ram_q ? ram_rd : alt_q;
  assign rd_en     = cmd_i.fetch || (cmd_i.copy && !run_last);
  assign rd_addr   = cmd_i.fetch ? rp_q : rp_q + POS_W'(1);
  assign win_ofs   = rd_addr - POS_W'(DICT_LENGTH);
  assign hit_valid = {1'b0, win_ofs} < fill_q;
  assign fwd       = cmd_i.copy && (rd_addr == wpos_q);
  assign wr_en     = cmd_i.literal || cmd_i.copy;
  assign wr_data   = cmd_i.literal ? in_byte : copy_byte;

  crlz_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_SIZE)
  ) u_window (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wpos_q),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(ram_rd)
  );

  always_comb begin
    cs_d        = cs_q;
    raw_d       = raw_q;
    cons_d      = cons_q;
    prod_d      = prod_q;
    wpos_d      = wpos_q;
    rp_d        = rp_q;
    fill_d      = fill_q;
    flags_d     = flags_q;
    ref_hi_d    = ref_hi_q;
    fidx_d      = fidx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    use_ram_d   = use_ram_q;
    alt_d       = alt_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COMPRESSED_SIZE: cs_d  = cfg_data_i;
        CFG_RAW_SIZE:        raw_d = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      wpos_d  = POS_W'(DICT_LENGTH);
      fill_d  = '0;
      flags_d = '0;
      fidx_d  = FIDX_W'(FLAGS_PER_BYTE);
      cons_d  = CNT_W'(HEADER_BYTES);
      prod_d  = '0;
    end

    if (cmd_i.flags_take) begin
      flags_d = in_byte;
      fidx_d  = '0;
      cons_d  = eff_cons + CNT_W'(1);
    end

    if (cmd_i.ref_high_take) begin
      ref_hi_d = in_byte;
    end

    if (cmd_i.literal) begin
      cons_d      = cons_q + CNT_W'(1);
      prod_d      = prod_q + CNT_W'(1);
      fidx_d      = fidx_q + FIDX_W'(1);
      wpos_d      = wpos_q + POS_W'(1);
      fill_d      = fill_full ? fill_q : fill_q + FILL_W'(1);
      out_valid_d = 1'b1;
      out_d       = '{out_byte: in_byte, last_of_run: 1'b1};
    end

    if (cmd_i.ref_start) begin
      rp_d   = {ref_hi_q, in_byte[7:4]};
      cnt_d  = LEN_W'(in_byte[3:0]) + LEN_W'(RUN_BIAS);
      cons_d = cons_q + CNT_W'(REF_BYTES);
      fidx_d = fidx_q + FIDX_W'(1);
    end

    if (cmd_i.copy) begin
      rp_d        = rp_q + POS_W'(1);
      cnt_d       = cnt_q - LEN_W'(1);
      prod_d      = prod_q + CNT_W'(1);
      wpos_d      = wpos_q + POS_W'(1);
      fill_d      = fill_full ? fill_q : fill_q + FILL_W'(1);
      out_valid_d = 1'b1;
      out_d       = '{out_byte: copy_byte, last_of_run: run_last};
    end

    if (rd_en) begin
      use_ram_d = !fwd && hit_valid;
      alt_d     = fwd ? copy_byte : rtf_dict_byte(rd_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q        <= '0;
      raw_q       <= '0;
      cons_q      <= CNT_W'(HEADER_BYTES);
      prod_q      <= '0;
      wpos_q      <= POS_W'(DICT_LENGTH);
      fill_q      <= '0;
      flags_q     <= '0;
      fidx_q      <= FIDX_W'(FLAGS_PER_BYTE);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cs_q        <= cs_d;
      raw_q       <= raw_d;
      cons_q      <= cons_d;
      prod_q      <= prod_d;
      wpos_q      <= wpos_d;
      fill_q      <= fill_d;
      flags_q     <= flags_d;
      fidx_q      <= fidx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_hi_q  <= ref_hi_d;
    rp_q      <= rp_d;
    out_q     <= out_d;
    use_ram_q <= use_ram_d;
    alt_q     <= alt_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_SIZE))
    else $error("crlz_datapath: fill count past window size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fidx_q <= FIDX_W'(FLAGS_PER_BYTE))
    else $error("crlz_datapath: flag index out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.copy |-> (cnt_q != '0))
    else $error("crlz_datapath: copy step with empty run");

endmodule

// ===== rtl/compressed_rtf_lz_decompressor.sv =====
// ============================================================================
// compressed_rtf_lz_decompressor: LZFU (compressed RTF) decoder
// Controller plus datapath; takes payload bytes, emits decompressed bytes.
// ============================================================================
// Usage:
//  - in channel: one compressed payload byte per item (header stripped);
//    new_stream=1 on the first byte of a stream reloads the window,
//    write position and counters before that byte is decoded.
//  - out channel: one decompressed byte per item; last_of_run marks the
//    final byte caused by one input item.
//  - cfg channel: index 0 = compressed_size, 1 = raw_size; always ready.
//    Write only while idle.
// Timing:
//  - flag byte, reference high byte, ignored byte: no output.
//  - literal: the byte is on the output the cycle after accept.
//  - reference low byte: accept, a window read, then one run byte per
//    cycle while the output is free (2..17 bytes); the window RAM's
//    single read port, read one byte ahead of each write, sets the rate.
// Reset: window reads as the RTF dictionary then zeros right away; a fill
//   count marks written slots, so no clearing pass is needed.
// Stall: a full, stalled output register holds its item and the input is
//   stalled until it drains; a run pauses in place.
// ============================================================================
module compressed_rtf_lz_decompressor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  crlz_pkg::crlz_in_t              in_data_i,
  // output items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output crlz_pkg::crlz_out_t             out_data_o,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [crlz_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [crlz_pkg::CNT_W-1:0]      cfg_data_i
);
  import crlz_pkg::*;

  crlz_cmd_t cmd;
  crlz_sts_t sts;
  logic      cfg_we;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  crlz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crlz_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule
